// ----- src/wfct_pkg.sv -----
// Shared types and constants for the weighted frequency count transform.
// No dependencies; every other file refers to it by scoped names.
package wfct_pkg;

    localparam int ALPHABET_SIZE_DEFAULT = 256;
    localparam int VALUE_W     = 8;
    localparam int WEIGHT_W    = 17;
    localparam int PERIOD_W    = 16;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    localparam logic [WEIGHT_W-1:0] WEIGHT_MAX   = {WEIGHT_W{1'b1}};
    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd4096;
    localparam logic [PERIOD_W-1:0] LIMIT_RESET  = 16'd1024;

    localparam logic [CFG_INDEX_W-1:0] CFG_DIRECTION      = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_HALVING_PERIOD = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_WEIGHT_LIMIT   = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_FIND   = 3'b010,
        S_UPDATE = 3'b100
    } state_t;

    typedef struct packed {
        logic                clear;
        logic                update;
        logic                halve;
        logic                direction;
        logic [WEIGHT_W-1:0] weight;
    } cell_ctrl_t;

endpackage

// ----- src/wfct_if.sv -----
// Handshake channel interfaces: input items, result items, register writes.
// Depends on wfct_pkg for field widths.
interface wfct_item_if;
    logic                             valid;
    logic                             ready;
    logic [wfct_pkg::VALUE_W-1:0]     value_in;
    logic                             message_start;
    modport source (output valid, output value_in, output message_start, input ready);
    modport sink   (input valid, input value_in, input message_start, output ready);
endinterface

interface wfct_result_if;
    logic                             valid;
    logic                             ready;
    logic [wfct_pkg::VALUE_W-1:0]     value_out;
    modport source (output valid, output value_out, input ready);
    modport sink   (input valid, input value_out, output ready);
endinterface

interface wfct_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [wfct_pkg::CFG_INDEX_W-1:0] index;
    logic [wfct_pkg::CFG_DATA_W-1:0]  data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- src/wfct_cell.sv -----
// One list entry: a symbol and its weight, compared in place and shifted
// toward the tail from its neighbor. Depends on wfct_pkg.
module wfct_cell #(
    parameter int INDEX = 0,
    parameter int SYM_W = 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  wfct_pkg::cell_ctrl_t          ctrl,
    input  logic [SYM_W-1:0]              key,
    input  logic [SYM_W-1:0]              pos,
    input  logic [SYM_W-1:0]              sym_new,
    input  logic [SYM_W-1:0]              prev_sym,
    input  logic [wfct_pkg::WEIGHT_W-1:0] prev_wt,
    output logic [SYM_W-1:0]              sym,
    output logic [wfct_pkg::WEIGHT_W-1:0] wt,
    output logic                          match
);

    localparam logic [SYM_W-1:0] IDX = SYM_W'(INDEX);

    logic [SYM_W-1:0]              sym_reg, sym_next;
    logic [wfct_pkg::WEIGHT_W-1:0] wt_reg, wt_next, wt_moved;
    logic                          take, head;

    assign sym   = ctrl.clear ? IDX : sym_reg;
    assign wt    = ctrl.clear ? '0 : wt_reg;
    assign match = ctrl.direction ? (IDX == key) : (sym == key);

    always_comb
    begin
        take     = (IDX <= pos) && (wt_reg <= ctrl.weight);
        head     = (INDEX == 0) || (prev_wt > ctrl.weight);
        sym_next = sym_reg;
        wt_moved = wt_reg;
        if (take)
        begin
            sym_next = head ? sym_new : prev_sym;
            wt_moved = head ? ctrl.weight : prev_wt;
        end
        wt_next = ctrl.halve ? (wt_moved >> 1) : wt_moved;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sym_reg <= IDX;
            wt_reg  <= '0;
        end
        else if (ctrl.clear)
        begin
            sym_reg <= IDX;
            wt_reg  <= '0;
        end
        else if (ctrl.update)
        begin
            sym_reg <= sym_next;
            wt_reg  <= wt_next;
        end
    end

endmodule

// ----- src/weighted_frequency_count_transform_top.sv -----
// Weighted frequency count list-update transform. Each item passes a find state, in which
// every cell of the list compares against the key at once and the hit is selected, and
// an update state, in which the cells shift toward the tail by one from their neighbor,
// the weight is stored and all weights halve when due. The item is registered on
// transfer and its result is written into the output registers in the find state; the
// next item is taken during the update state, never during the find state. Two result
// registers sit at the output; outside the find state the input stalls only while both
// hold results not yet taken. An item whose value lies outside the alphabet skips the
// update state and leaves the list unchanged; the next item is taken in the idle state
// after its find state. Message start clears the list within the find state, also for
// an item outside the alphabet.
// Depends on wfct_pkg, wfct_if and wfct_cell.
module weighted_frequency_count_transform_top #(
    parameter int ALPHABET_SIZE = wfct_pkg::ALPHABET_SIZE_DEFAULT
) (
    input  logic                 clk,
    input  logic                 rst_n,
    wfct_item_if.sink            item,
    wfct_result_if.source        result,
    wfct_cfg_if.sink             cfg
);

    localparam int SYM_W = (ALPHABET_SIZE > 1) ? $clog2(ALPHABET_SIZE) : 1;
    localparam int CMP_W = ((SYM_W > wfct_pkg::VALUE_W) ? SYM_W : wfct_pkg::VALUE_W) + 1;
    localparam int WW    = wfct_pkg::WEIGHT_W;
    localparam int VW    = wfct_pkg::VALUE_W;
    localparam int PW    = wfct_pkg::PERIOD_W;

    wfct_pkg::state_t state_reg, state_next;

    logic              direction_reg;
    logic [PW-1:0]     period_reg, limit_reg, cnt_reg, cnt_dec;
    logic [VW-1:0]     value_reg;
    logic              start_reg;
    logic [SYM_W-1:0]  pos_reg, sym_reg, pos_sel, sym_sel;
    logic [WW-1:0]     w_reg, wt_sel, w_inc, front_wt;
    logic              out_valid_reg;
    logic [VW-1:0]     out_value_reg;
    logic              spare_valid_reg;
    logic [VW-1:0]     spare_value_reg;
    logic              out_push, out_pop;
    logic [VW-1:0]     new_value;
    logic              in_take, in_range, halve;
    logic [SYM_W-1:0]  key;
    logic [SYM_W-1:0]  raw;

    wfct_pkg::cell_ctrl_t ctrl;

    logic [SYM_W-1:0] cell_sym [ALPHABET_SIZE];
    logic [WW-1:0]    cell_wt  [ALPHABET_SIZE];
    logic             cell_hit [ALPHABET_SIZE];

    assign cfg.ready    = 1'b1;
    assign item.ready   = ((state_reg == wfct_pkg::S_IDLE) || (state_reg == wfct_pkg::S_UPDATE))
                          && !spare_valid_reg;
    assign in_take      = item.valid && item.ready;
    assign result.valid = out_valid_reg;
    assign result.value_out = out_value_reg;

    assign out_push  = (state_reg == wfct_pkg::S_FIND);
    assign out_pop   = out_valid_reg && result.ready;
    assign new_value = in_range ? VW'(raw) : '0;

    assign in_range = CMP_W'(value_reg) < CMP_W'(ALPHABET_SIZE);
    assign key      = SYM_W'(value_reg);

    always_comb
    begin
        pos_sel = '0;
        sym_sel = '0;
        wt_sel  = '0;
        for (int i = 0; i < ALPHABET_SIZE; i++)
        begin
            if (cell_hit[i])
            begin
                pos_sel = pos_sel | SYM_W'(i);
                sym_sel = sym_sel | cell_sym[i];
                wt_sel  = wt_sel  | cell_wt[i];
            end
        end
        w_inc = (wt_sel == wfct_pkg::WEIGHT_MAX) ? wt_sel : wt_sel + WW'(1);
        raw   = direction_reg ? sym_sel : pos_sel;
    end

    always_comb
    begin
        cnt_dec  = cnt_reg - PW'(1);
        front_wt = (cell_wt[0] <= w_reg) ? w_reg : cell_wt[0];
        halve    = (state_reg == wfct_pkg::S_UPDATE)
                   && ((cnt_dec == '0) || (front_wt > WW'(limit_reg)));
        ctrl.clear     = (state_reg == wfct_pkg::S_FIND) && start_reg;
        ctrl.update    = (state_reg == wfct_pkg::S_UPDATE);
        ctrl.halve     = halve;
        ctrl.direction = direction_reg;
        ctrl.weight    = w_reg;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            wfct_pkg::S_IDLE:
                if (in_take)
                    state_next = wfct_pkg::S_FIND;
            wfct_pkg::S_FIND:
                state_next = in_range ? wfct_pkg::S_UPDATE : wfct_pkg::S_IDLE;
            wfct_pkg::S_UPDATE:
                state_next = in_take ? wfct_pkg::S_FIND : wfct_pkg::S_IDLE;
            default:
                state_next = wfct_pkg::S_IDLE;
        endcase
    end

    generate
        for (genvar g = 0; g < ALPHABET_SIZE; g++)
        begin : g_cell
            logic [SYM_W-1:0] prev_sym;
            logic [WW-1:0]    prev_wt;
            if (g == 0)
            begin : g_head
                assign prev_sym = '0;
                assign prev_wt  = '0;
            end
            else
            begin : g_link
                assign prev_sym = cell_sym[g-1];
                assign prev_wt  = cell_wt[g-1];
            end
            wfct_cell #(
                .INDEX (g),
                .SYM_W (SYM_W)
            ) u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .ctrl     (ctrl),
                .key      (key),
                .pos      (pos_reg),
                .sym_new  (sym_reg),
                .prev_sym (prev_sym),
                .prev_wt  (prev_wt),
                .sym      (cell_sym[g]),
                .wt       (cell_wt[g]),
                .match    (cell_hit[g])
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= wfct_pkg::S_IDLE;
            direction_reg   <= 1'b0;
            period_reg      <= wfct_pkg::PERIOD_RESET;
            limit_reg       <= wfct_pkg::LIMIT_RESET;
            cnt_reg         <= wfct_pkg::PERIOD_RESET;
            out_valid_reg   <= 1'b0;
            spare_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg.valid)
            begin
                case (cfg.index)
                    wfct_pkg::CFG_DIRECTION:      direction_reg <= cfg.data[0];
                    wfct_pkg::CFG_HALVING_PERIOD: period_reg    <= cfg.data;
                    wfct_pkg::CFG_WEIGHT_LIMIT:   limit_reg     <= cfg.data;
                    default:                      ;
                endcase
            end
            if (ctrl.clear)
                cnt_reg <= period_reg;
            else if (ctrl.update)
                cnt_reg <= halve ? period_reg : cnt_dec;
            if (out_pop)
            begin
                out_valid_reg   <= spare_valid_reg || out_push;
                spare_valid_reg <= spare_valid_reg && out_push;
            end
            else if (out_push)
            begin
                out_valid_reg   <= 1'b1;
                spare_valid_reg <= out_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            value_reg <= item.value_in;
            start_reg <= item.message_start;
        end
        if (state_reg == wfct_pkg::S_FIND)
        begin
            pos_reg <= pos_sel;
            sym_reg <= sym_sel;
            w_reg   <= w_inc;
        end
        if (out_pop)
        begin
            out_value_reg   <= spare_valid_reg ? spare_value_reg : new_value;
            spare_value_reg <= new_value;
        end
        else if (out_push)
        begin
            if (out_valid_reg)
                spare_value_reg <= new_value;
            else
                out_value_reg <= new_value;
        end
    end

    a_result_after_find: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == wfct_pkg::S_FIND))
        else $error("result raised outside find cycle");

    a_no_take_in_find: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == wfct_pkg::S_FIND) |-> !in_take)
        else $error("item transfer during find cycle");

    a_halve_reload: assert property (@(posedge clk) disable iff (!rst_n)
        halve |=> (cnt_reg == $past(period_reg)))
        else $error("countdown not reloaded on halving");

    a_clear_front: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.clear |=> (cell_wt[0] == '0) && (cell_sym[0] == '0))
        else $error("message start did not clear list front");

    a_spare_room: assert property (@(posedge clk) disable iff (!rst_n)
        out_push |-> !spare_valid_reg)
        else $error("result pushed with both output registers full");

endmodule

// ----- bench/testbench.sv -----
// Self-checking bench for the weighted frequency count transform: directed rows, then random
// phases over encode and decode, halving periods and weight limits, with idle and stall mixes.
// Depends on wfct_pkg, the wfct_if interfaces and weighted_frequency_count_transform_top.
module testbench;

    localparam int ALPHA        = wfct_pkg::ALPHABET_SIZE_DEFAULT;
    localparam int VW           = wfct_pkg::VALUE_W;
    localparam int WW           = wfct_pkg::WEIGHT_W;
    localparam int PW           = wfct_pkg::PERIOD_W;
    localparam int IW           = wfct_pkg::CFG_INDEX_W;
    localparam int DW           = wfct_pkg::CFG_DATA_W;
    localparam int DRAIN_CYCLES = 4;
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 200;
    localparam int SHOWN_ERRORS = 10;

    localparam logic DIR_ENCODE = 1'b0;
    localparam logic DIR_DECODE = 1'b1;

    typedef struct packed {
        logic          decode;
        logic [PW-1:0] period;
        logic [PW-1:0] limit;
        logic [VW-1:0] value;
        logic          start;
        logic          known;
        logic [VW-1:0] want;
    } step_row_t;

    logic clk;
    logic rst_n;

    wfct_item_if   item_ch();
    wfct_result_if result_ch();
    wfct_cfg_if    cfg_ch();

    weighted_frequency_count_transform_top u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    // mirror of the list, weights, countdown and registers
    int unsigned    rank_list [ALPHA];
    logic [WW-1:0]  sym_weight [ALPHA];
    logic [PW-1:0]  countdown;
    logic           dir_m;
    logic [PW-1:0]  period_m;
    logic [PW-1:0]  limit_m;

    logic [VW-1:0]  expected_values [$];
    logic           row_known;
    logic [VW-1:0]  row_want;

    int mismatch_count;
    int items_accepted;
    int results_seen;
    int starts_sent;
    int settings_applied;
    int src_idle_pct;
    int sink_stall_pct;

    step_row_t directed_steps [24] = '{
        '{DIR_ENCODE, 16'd4096,  16'd1024,  8'd0,   1'b0, 1'b1, 8'd0},
        '{DIR_ENCODE, 16'd4096,  16'd1024,  8'd255, 1'b1, 1'b1, 8'd255},
        '{DIR_ENCODE, 16'd4096,  16'd1024,  8'd255, 1'b0, 1'b1, 8'd0},
        '{DIR_ENCODE, 16'd4096,  16'd1024,  8'd0,   1'b0, 1'b1, 8'd1},
        '{DIR_ENCODE, 16'd4096,  16'd1024,  8'd128, 1'b0, 1'b0, 8'd0},
        '{DIR_ENCODE, 16'd4096,  16'd1024,  8'd255, 1'b0, 1'b0, 8'd0},
        '{DIR_ENCODE, 16'd4096,  16'd1024,  8'd170, 1'b0, 1'b0, 8'd0},
        '{DIR_ENCODE, 16'd4096,  16'd1024,  8'd85,  1'b0, 1'b0, 8'd0},
        '{DIR_ENCODE, 16'd1,     16'd0,     8'd7,   1'b1, 1'b1, 8'd7},
        '{DIR_ENCODE, 16'd1,     16'd0,     8'd7,   1'b0, 1'b0, 8'd0},
        '{DIR_ENCODE, 16'd1,     16'd0,     8'd200, 1'b0, 1'b0, 8'd0},
        '{DIR_DECODE, 16'd1,     16'd0,     8'd0,   1'b1, 1'b1, 8'd0},
        '{DIR_DECODE, 16'd1,     16'd0,     8'd255, 1'b0, 1'b1, 8'd255},
        '{DIR_DECODE, 16'd1,     16'd0,     8'd255, 1'b0, 1'b0, 8'd0},
        '{DIR_DECODE, 16'd65535, 16'd65535, 8'd0,   1'b1, 1'b1, 8'd0},
        '{DIR_DECODE, 16'd65535, 16'd65535, 8'd128, 1'b0, 1'b0, 8'd0},
        '{DIR_DECODE, 16'd65535, 16'd65535, 8'd1,   1'b0, 1'b0, 8'd0},
        '{DIR_DECODE, 16'd0,     16'd3,     8'd0,   1'b0, 1'b0, 8'd0},
        '{DIR_DECODE, 16'd0,     16'd3,     8'd0,   1'b0, 1'b0, 8'd0},
        '{DIR_DECODE, 16'd0,     16'd3,     8'd0,   1'b0, 1'b0, 8'd0},
        '{DIR_DECODE, 16'd0,     16'd3,     8'd0,   1'b0, 1'b0, 8'd0},
        '{DIR_DECODE, 16'd0,     16'd3,     8'd0,   1'b0, 1'b0, 8'd0},
        '{DIR_ENCODE, 16'd0,     16'd3,     8'd170, 1'b1, 1'b1, 8'd170},
        '{DIR_ENCODE, 16'd0,     16'd3,     8'd85,  1'b0, 1'b0, 8'd0}
    };

    function automatic void restart_message();
        int k;
        for (k = 0; k < ALPHA; k++)
        begin
            rank_list[k]  = k;
            sym_weight[k] = '0;
        end
        countdown = period_m;
    endfunction

    function automatic logic [VW-1:0] transform_symbol(input logic [VW-1:0] v,
                                                        input logic start);
        int unsigned   pos;
        int unsigned   sym;
        int unsigned   border;
        int            k;
        logic [WW-1:0] w;
        logic [VW-1:0] outv;
        if (start)
            restart_message();
        if (int'(v) >= ALPHA)
            return '0;
        if (dir_m == DIR_ENCODE)
        begin
            sym = v;
            pos = 0;
            while (pos < ALPHA - 1 && rank_list[pos] != sym)
                pos++;
            outv = pos[VW-1:0];
        end
        else
        begin
            pos  = v;
            sym  = rank_list[pos];
            outv = sym[VW-1:0];
        end
        w = sym_weight[sym];
        if (w != wfct_pkg::WEIGHT_MAX)
            w = w + 1'b1;
        sym_weight[sym] = w;
        border = 0;
        while (border < pos && sym_weight[rank_list[border]] > w)
            border++;
        for (k = pos; k > border; k--)
            rank_list[k] = rank_list[k-1];
        rank_list[border] = sym;
        countdown = countdown - 1'b1;
        if (countdown == '0 || sym_weight[rank_list[0]] > {1'b0, limit_m})
        begin
            countdown = period_m;
            for (k = 0; k < ALPHA; k++)
                sym_weight[k] = sym_weight[k] >> 1;
        end
        return outv;
    endfunction

    task automatic report_mismatch(input string what, input logic [VW-1:0] want,
                                   input logic [VW-1:0] got);
        mismatch_count++;
        if (mismatch_count <= SHOWN_ERRORS)
            $display("error: %s at result %0d: expected %0d, got %0d", what, results_seen,
                     want, got);
    endtask

    always @(posedge clk)
    begin
        logic [VW-1:0] predicted;
        logic [VW-1:0] want;
        if (rst_n)
        begin
            if (item_ch.valid && item_ch.ready)
            begin
                predicted = transform_symbol(item_ch.value_in, item_ch.message_start);
                expected_values.push_back(row_known ? row_want : predicted);
                items_accepted++;
            end
            if (result_ch.valid && result_ch.ready)
            begin
                if (expected_values.size() == 0)
                    report_mismatch("unexpected transfer", '0, result_ch.value_out);
                else
                begin
                    want = expected_values.pop_front();
                    if (result_ch.value_out !== want)
                        report_mismatch("value_out", want, result_ch.value_out);
                end
                results_seen++;
            end
        end
    end

    always @(negedge clk)
        result_ch.ready = ($urandom_range(99) >= sink_stall_pct);

    task automatic push_item(input logic [VW-1:0] v, input logic start,
                             input logic known, input logic [VW-1:0] want);
        @(negedge clk);
        while (src_idle_pct > 0 && $urandom_range(99) < src_idle_pct)
        begin
            item_ch.valid = 1'b0;
            @(negedge clk);
        end
        item_ch.valid         = 1'b1;
        item_ch.value_in      = v;
        item_ch.message_start = start;
        row_known             = known;
        row_want              = want;
        if (start)
            starts_sent++;
        do
            @(posedge clk);
        while (!item_ch.ready);
    endtask

    task automatic wait_idle();
        @(negedge clk);
        item_ch.valid = 1'b0;
        while (expected_values.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input logic [IW-1:0] idx, input logic [DW-1:0] val);
        @(negedge clk);
        cfg_ch.valid = 1'b1;
        cfg_ch.index = idx;
        cfg_ch.data  = val;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        case (idx)
            wfct_pkg::CFG_DIRECTION:      dir_m    = val[0];
            wfct_pkg::CFG_HALVING_PERIOD: period_m = val;
            wfct_pkg::CFG_WEIGHT_LIMIT:   limit_m  = val;
            default:                      ;
        endcase
        @(negedge clk);
        cfg_ch.valid = 1'b0;
    endtask

    task automatic apply_settings(input logic decode, input logic [PW-1:0] period,
                                  input logic [PW-1:0] limit);
        wait_idle();
        write_register(wfct_pkg::CFG_DIRECTION, {{(DW-1){1'b0}}, decode});
        write_register(wfct_pkg::CFG_HALVING_PERIOD, period);
        write_register(wfct_pkg::CFG_WEIGHT_LIMIT, limit);
        settings_applied++;
    endtask

    function automatic logic [VW-1:0] pick_value(input logic decode, input int hot_base);
        int r;
        r = $urandom_range(99);
        if (r < 60)
            return decode ? VW'($urandom_range(7)) : VW'(hot_base + $urandom_range(11));
        else if (r < 80)
            return VW'($urandom_range(31));
        return VW'($urandom_range(255));
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #4_000_000;
        $display("timeout: %0d items accepted, %0d results seen", items_accepted, results_seen);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        int            i;
        int            p;
        int            n;
        int            hot_base;
        logic          decode;
        logic [PW-1:0] period;
        logic [PW-1:0] limit;
        step_row_t     row;

        rst_n                 = 1'b0;
        item_ch.valid         = 1'b0;
        item_ch.value_in      = '0;
        item_ch.message_start = 1'b0;
        result_ch.ready       = 1'b0;
        cfg_ch.valid          = 1'b0;
        cfg_ch.index          = wfct_pkg::CFG_DIRECTION;
        cfg_ch.data           = '0;
        row_known             = 1'b0;
        row_want              = '0;
        mismatch_count        = 0;
        items_accepted        = 0;
        results_seen          = 0;
        starts_sent           = 0;
        settings_applied      = 0;
        src_idle_pct          = 0;
        sink_stall_pct        = 0;
        dir_m                 = DIR_ENCODE;
        period_m              = wfct_pkg::PERIOD_RESET;
        limit_m               = wfct_pkg::LIMIT_RESET;
        restart_message();

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (i = 0; i < $size(directed_steps); i++)
        begin
            row = directed_steps[i];
            if (row.decode != dir_m || row.period != period_m || row.limit != limit_m)
                apply_settings(row.decode, row.period, row.limit);
            push_item(row.value, row.start, row.known, row.want);
        end

        for (p = 0; p < PHASES; p++)
        begin
            decode = p[0] ? DIR_DECODE : DIR_ENCODE;
            case (p)
                0:       begin period = 16'd4096;  limit = 16'd1024;  end
                1:       begin period = 16'd1;     limit = 16'd0;     end
                2:       begin period = 16'd65535; limit = 16'd65535; end
                3:       begin period = 16'd0;     limit = 16'd5;     end
                default:
                begin
                    period = PW'($urandom_range(1, 300));
                    limit  = PW'($urandom_range(0, 60));
                end
            endcase
            apply_settings(decode, period, limit);
            case (p % 4)
                0:       begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1:       begin src_idle_pct = 52; sink_stall_pct = 0;  end
                2:       begin src_idle_pct = 0;  sink_stall_pct = 52; end
                default: begin src_idle_pct = 24; sink_stall_pct = 24; end
            endcase
            hot_base = $urandom_range(0, 244);
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                // hold the sender until every result is back
                if (n == PHASE_ITEMS / 2)
                    wait_idle();
                push_item(pick_value(decode, hot_base), ($urandom_range(99) < 2), 1'b0, '0);
            end
        end

        src_idle_pct = 0;
        wait_idle();
        if (expected_values.size() != 0)
            report_mismatch("missing transfer", expected_values[0], '0);

        $display("covered %0d items, %0d results, %0d message starts over %0d settings",
                 items_accepted, results_seen, starts_sent, settings_applied);
        $display("encode and decode, periods 0 to 65535, limits 0 to 65535; %0d mismatches",
                 mismatch_count);
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
